// ===== rtl/hpe_pkg.sv =====
package hpe_pkg;

	localparam int MAX_WIDTH     = 1024;
	localparam int MAX_HEIGHT    = 1024;
	localparam int SCORE_BITS    = 16;
	localparam int NUM_CLASSES   = 2;
	localparam int INPUT_CLASSES = 2;
	localparam int CENTRES       = 4;

	localparam int POS_BITS       = 10;
	localparam int SIZE_BITS      = 11;
	localparam int THR_BITS       = 16;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 16;

	localparam logic [SIZE_BITS-1:0] FRAME_WIDTH_RESET  = SIZE_BITS'(512);
	localparam logic [SIZE_BITS-1:0] FRAME_HEIGHT_RESET = SIZE_BITS'(512);
	localparam logic [THR_BITS-1:0]  THRESHOLD_RESET    = THR_BITS'(32768);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_FRAME_WIDTH,
		REG_FRAME_HEIGHT,
		REG_SCORE_THRESHOLD
	} reg_index_t;

	typedef struct packed {
		logic [POS_BITS-1:0] row;
		logic [POS_BITS-1:0] col;
		logic                cls;
	} peak_tag_t;

endpackage

// ===== rtl/hpe_if.sv =====
interface hpe_pix_if #(
	parameter int SCORE_BITS = hpe_pkg::SCORE_BITS
);
	logic                  valid;
	logic                  ready;
	logic [SCORE_BITS-1:0] score_vehicle;
	logic [SCORE_BITS-1:0] score_person;

	modport source (output valid, output score_vehicle, output score_person, input ready);
	modport sink (input valid, input score_vehicle, input score_person, output ready);
endinterface

interface hpe_peak_if #(
	parameter int SCORE_BITS = hpe_pkg::SCORE_BITS
);
	logic                         valid;
	logic                         ready;
	logic [hpe_pkg::POS_BITS-1:0] peak_col;
	logic [hpe_pkg::POS_BITS-1:0] peak_row;
	logic                         peak_class;
	logic [SCORE_BITS-1:0]        peak_score;
	logic                         last_of_item;

	modport source (output valid, output peak_col, output peak_row, output peak_class,
		output peak_score, output last_of_item, input ready);
	modport sink (input valid, input peak_col, input peak_row, input peak_class,
		input peak_score, input last_of_item, output ready);
endinterface

interface hpe_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [hpe_pkg::CFG_INDEX_BITS-1:0] index;
	logic [hpe_pkg::CFG_DATA_BITS-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/hpe_line_mem.sv =====
module hpe_line_mem #(
	parameter int DEPTH  = hpe_pkg::MAX_WIDTH,
	parameter int DATA_W = 2 * hpe_pkg::NUM_CLASSES * hpe_pkg::SCORE_BITS
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/hpe_peak_emit.sv =====
module hpe_peak_emit #(
	parameter int NCAND      = hpe_pkg::CENTRES * hpe_pkg::NUM_CLASSES,
	parameter int SCORE_BITS = hpe_pkg::SCORE_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [NCAND-1:0]                      load_mask,
	input  logic [NCAND-1:0][SCORE_BITS-1:0]      load_score,
	input  hpe_pkg::peak_tag_t [NCAND-1:0]        load_tag,
	output logic                                  free,
	hpe_peak_if.source                            peak
);

	localparam int IW = $clog2(NCAND);

	logic [NCAND-1:0]                 mask_q;
	logic [NCAND-1:0][SCORE_BITS-1:0] score_q;
	hpe_pkg::peak_tag_t [NCAND-1:0]   tag_q;
	logic [NCAND-1:0]                 rest;
	logic [IW-1:0]                    idx;
	logic                             pick;

	logic                  ovalid_q;
	hpe_pkg::peak_tag_t    otag_q;
	logic [SCORE_BITS-1:0] oscore_q;
	logic                  olast_q;

	// lowest pending candidate goes first
	always_comb begin
		idx = '0;
		for (int j = NCAND - 1; j >= 0; j--) begin
			if (mask_q[j]) begin
				idx = IW'(j);
			end
		end
	end

	assign rest = mask_q & (mask_q - NCAND'(1));
	assign pick = (|mask_q) && (!ovalid_q || peak.ready);
	assign free = (mask_q == '0) || (pick && (rest == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (free) begin
				mask_q <= load_mask;
			end else if (pick) begin
				mask_q <= rest;
			end
			if (pick) begin
				ovalid_q <= 1'b1;
			end else if (peak.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free) begin
			score_q <= load_score;
			tag_q   <= load_tag;
		end
		if (pick) begin
			otag_q   <= tag_q[idx];
			oscore_q <= score_q[idx];
			olast_q  <= (rest == '0);
		end
	end

	assign peak.valid        = ovalid_q;
	assign peak.peak_col     = otag_q.col;
	assign peak.peak_row     = otag_q.row;
	assign peak.peak_class   = otag_q.cls;
	assign peak.peak_score   = oscore_q;
	assign peak.last_of_item = olast_q;

endmodule

// ===== rtl/heatmap_peak_extract_3x3.sv =====
// channel  direction  handshake          payload
// cfg      in         cfg.valid/ready    index, data (frame_width, frame_height, threshold)
// pix      in         pix.valid/ready    score_vehicle, score_person
// peak     out        peak.valid/ready   peak_col, peak_row, peak_class, peak_score,
//                                        last_of_item
// one pixel per cycle while each pixel yields at most one peak and peak.ready is high;
// a pixel with more peaks holds the serializer: one peak per cycle while peak.ready is high
// pixel to peak path: line ram read, window, judge into the pending set, out reg
// line ram: one read and one write port, written back as the pixel leaves stage 1,
// same-column reuse (width one) forwarded
// arst_n clears counters, pipeline valids, result queue and config to defaults; no ram clear
// a stalled peak channel holds the pipeline once the pending peak set is not drained
module heatmap_peak_extract_3x3 #(
	parameter int MAX_WIDTH   = hpe_pkg::MAX_WIDTH,
	parameter int SCORE_BITS  = hpe_pkg::SCORE_BITS,
	parameter int NUM_CLASSES = hpe_pkg::NUM_CLASSES
) (
	input logic        clk,
	input logic        arst_n,
	hpe_cfg_if.sink    cfg,
	hpe_pix_if.sink    pix,
	hpe_peak_if.source peak
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int NC    = NUM_CLASSES;
	localparam int SB    = SCORE_BITS;
	localparam int NCAND = hpe_pkg::CENTRES * NC;
	localparam int MEM_W = 2 * NC * SB;
	localparam int RB    = hpe_pkg::POS_BITS;
	localparam int HB    = hpe_pkg::SIZE_BITS;
	localparam int EW    = (CW + 1 > HB) ? CW + 1 : HB;
	localparam int PW    = (CW > RB) ? CW : RB;
	localparam int TW    = (SB > hpe_pkg::THR_BITS) ? SB : hpe_pkg::THR_BITS;

	localparam int CEN_R [hpe_pkg::CENTRES] = '{1, 1, 2, 2};
	localparam int CEN_C [hpe_pkg::CENTRES] = '{1, 2, 1, 2};

	typedef logic [SB-1:0] score_t;

	// configuration
	logic [HB-1:0]                    fw_q;
	logic [HB-1:0]                    fh_q;
	logic [hpe_pkg::THR_BITS-1:0]     thr_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q  <= hpe_pkg::FRAME_WIDTH_RESET;
			fh_q  <= hpe_pkg::FRAME_HEIGHT_RESET;
			thr_q <= hpe_pkg::THRESHOLD_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				hpe_pkg::REG_FRAME_WIDTH: begin
					fw_q <= cfg.data[HB-1:0];
				end
				hpe_pkg::REG_FRAME_HEIGHT: begin
					fh_q <= cfg.data[HB-1:0];
				end
				hpe_pkg::REG_SCORE_THRESHOLD: begin
					thr_q <= cfg.data[hpe_pkg::THR_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// raster position
	logic [CW-1:0] col_q;
	logic [RB-1:0] row_q;
	logic [EW-1:0] fw_x;
	logic [EW-1:0] weff;
	logic [HB-1:0] heff;
	logic          lastc;
	logic          lastr;
	logic          adv;
	logic          acc;

	assign fw_x  = EW'(fw_q);
	assign weff  = (fw_x == '0) ? EW'(1) : ((fw_x > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : fw_x);
	assign heff  = (fh_q == '0) ? HB'(1) :
		((fh_q > HB'(hpe_pkg::MAX_HEIGHT)) ? HB'(hpe_pkg::MAX_HEIGHT) : fh_q);
	assign lastc = (EW'(col_q) + EW'(1)) >= weff;
	assign lastr = (HB'(row_q) + HB'(1)) >= heff;

	assign pix.ready = adv;
	assign acc       = pix.valid && adv;

	score_t cur_in [NC];

	for (genvar k = 0; k < NC; k++) begin : g_in
		if (k == 0) begin : g_veh
			assign cur_in[k] = pix.score_vehicle;
		end else if (k == 1) begin : g_per
			assign cur_in[k] = pix.score_person;
		end else begin : g_none
			assign cur_in[k] = '0;
		end
	end

	// stage 1: line ram data back, window column built
	logic             valid_s1;
	score_t           cur_s1 [NC];
	logic [CW-1:0]    c_s1;
	logic [RB-1:0]    r_s1;
	logic             lastc_s1;
	logic             lastr_s1;
	logic             fwd_s1;
	logic [MEM_W-1:0] fwd_data_s1;

	logic [MEM_W-1:0] mem_rd;
	logic [MEM_W-1:0] line_rd;
	logic [MEM_W-1:0] wr_data;
	score_t           older [NC];
	score_t           newer [NC];
	logic             wr_en;

	assign wr_en = valid_s1 && adv;

	always_comb begin
		line_rd = fwd_s1 ? fwd_data_s1 : mem_rd;
		for (int k = 0; k < NC; k++) begin
			older[k] = line_rd[(NC + k) * SB +: SB];
			newer[k] = line_rd[k * SB +: SB];
			wr_data[(NC + k) * SB +: SB] = newer[k];
			wr_data[k * SB +: SB] = cur_s1[k];
		end
	end

	hpe_line_mem #(
		.DEPTH  (MAX_WIDTH),
		.DATA_W (MEM_W)
	) u_line_mem (
		.clk     (clk),
		.rd_en   (acc),
		.rd_addr (col_q),
		.rd_data (mem_rd),
		.wr_en   (wr_en),
		.wr_addr (c_s1),
		.wr_data (wr_data)
	);

	// stage 2: window registers hold the neighborhood
	logic          valid_s2;
	score_t        win_q [3][3][NC];
	logic [CW-1:0] c_s2;
	logic [RB-1:0] r_s2;
	logic          lastc_s2;
	logic          lastr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
		end else if (adv) begin
			valid_s1 <= acc;
			valid_s2 <= valid_s1;
			if (acc) begin
				if (lastc) begin
					col_q <= '0;
					row_q <= lastr ? '0 : row_q + RB'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cur_s1      <= cur_in;
			c_s1        <= col_q;
			r_s1        <= row_q;
			lastc_s1    <= lastc;
			lastr_s1    <= lastr;
			fwd_s1      <= valid_s1 && (c_s1 == col_q);
			fwd_data_s1 <= wr_data;
		end
		if (wr_en) begin
			for (int rr = 0; rr < 3; rr++) begin
				for (int k = 0; k < NC; k++) begin
					win_q[rr][0][k] <= win_q[rr][1][k];
					win_q[rr][1][k] <= win_q[rr][2][k];
				end
			end
			for (int k = 0; k < NC; k++) begin
				win_q[0][2][k] <= older[k];
				win_q[1][2][k] <= newer[k];
				win_q[2][2][k] <= cur_s1[k];
			end
			c_s2     <= c_s1;
			r_s2     <= r_s1;
			lastc_s2 <= lastc_s1;
			lastr_s2 <= lastr_s1;
		end
	end

	// judge up to four centers per class
	logic [2:0]                       rv;
	logic [2:0]                       cv;
	logic [hpe_pkg::CENTRES-1:0]      cen_en;
	logic [RB-1:0]                    rm1;
	logic [PW-1:0]                    colx;
	logic [PW-1:0]                    cm1;
	logic [NCAND-1:0]                 hit;
	logic [NCAND-1:0]                 load_mask;
	logic [NCAND-1:0][SB-1:0]         cand_score;
	hpe_pkg::peak_tag_t [NCAND-1:0]   cand_tag;

	assign rv     = {1'b1, r_s2 >= RB'(1), r_s2 >= RB'(2)};
	assign cv     = {1'b1, c_s2 >= CW'(1), c_s2 >= CW'(2)};
	assign cen_en = {lastr_s2 && lastc_s2, lastr_s2 && cv[1], rv[1] && lastc_s2, rv[1] && cv[1]};
	assign rm1    = r_s2 - RB'(1);
	assign colx   = PW'(c_s2);
	assign cm1    = colx - PW'(1);

	always_comb begin
		int     wr;
		int     wc;
		score_t s;
		logic   ok;
		for (int i = 0; i < hpe_pkg::CENTRES; i++) begin
			wr = CEN_R[i];
			wc = CEN_C[i];
			for (int k = 0; k < NC; k++) begin
				s  = win_q[wr][wc][k];
				ok = 1'b1;
				for (int rr = wr - 1; rr <= 2 && rr <= wr + 1; rr++) begin
					for (int cc = wc - 1; cc <= 2 && cc <= wc + 1; cc++) begin
						if (rv[rr] && cv[cc] && (win_q[rr][cc][k] > s)) begin
							ok = 1'b0;
						end
					end
				end
				hit[i * NC + k]          = cen_en[i] && ok && (TW'(s) > TW'(thr_q));
				cand_score[i * NC + k]   = s;
				cand_tag[i * NC + k].row = (wr == 1) ? rm1 : r_s2;
				cand_tag[i * NC + k].col = (wc == 1) ? cm1[RB-1:0] : colx[RB-1:0];
				cand_tag[i * NC + k].cls = k[0];
			end
		end
	end

	assign load_mask = valid_s2 ? hit : '0;

	// stage 3: pending peaks, one transfer per cycle while peak.ready is high
	hpe_peak_emit #(
		.NCAND      (NCAND),
		.SCORE_BITS (SB)
	) u_peak_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_mask  (load_mask),
		.load_score (cand_score),
		.load_tag   (cand_tag),
		.free       (adv),
		.peak       (peak)
	);

	a_acc_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> valid_s1)
		else $error("accepted pixel did not reach stage 1");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= CW'(MAX_WIDTH - 1))
		else $error("column counter beyond line ram depth");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(c_s1) && $stable(r_s1))
		else $error("stage 1 changed while stalled");

	a_fwd_col0: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && fwd_s1 |-> c_s1 == '0)
		else $error("line forwarding outside single column frame");

endmodule

// ===== test/tb_heatmap_peak_extract_3x3.sv =====
`timescale 1ns / 1ps

module tb_heatmap_peak_extract_3x3;

	localparam int MAX_WIDTH     = hpe_pkg::MAX_WIDTH;
	localparam int MAX_HEIGHT    = hpe_pkg::MAX_HEIGHT;
	localparam int SCORE_BITS    = hpe_pkg::SCORE_BITS;
	localparam int NUM_CLASSES   = hpe_pkg::NUM_CLASSES;
	localparam int POS_BITS      = hpe_pkg::POS_BITS;
	localparam int SIZE_BITS     = hpe_pkg::SIZE_BITS;
	localparam int THR_BITS      = hpe_pkg::THR_BITS;
	localparam int CFG_DATA_BITS = hpe_pkg::CFG_DATA_BITS;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 12;
	localparam int RANDOM_PIXELS = 230;

	typedef enum int {FILL_FULL, FILL_TIES, FILL_SPIKY, FILL_FLAT} fill_t;

	typedef struct packed {
		logic [SCORE_BITS-1:0] veh;
		logic [SCORE_BITS-1:0] per;
	} pixel_t;

	typedef struct packed {
		logic [POS_BITS-1:0]   col;
		logic [POS_BITS-1:0]   row;
		logic                  cls;
		logic [SCORE_BITS-1:0] score;
		logic                  last;
	} peak_rec_t;

	logic clk = 1'b0;
	logic arst_n;

	hpe_cfg_if  cfg ();
	hpe_pix_if  pix ();
	hpe_peak_if peak ();

	heatmap_peak_extract_3x3 u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.pix    (pix),
		.peak   (peak)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic [SCORE_BITS-1:0] line_old [MAX_WIDTH][NUM_CLASSES];
	logic [SCORE_BITS-1:0] line_new [MAX_WIDTH][NUM_CLASSES];
	logic [SCORE_BITS-1:0] win [3][3][NUM_CLASSES];
	int unsigned col_cnt = 0;
	int unsigned row_cnt = 0;
	logic [SIZE_BITS-1:0] cfg_width  = hpe_pkg::FRAME_WIDTH_RESET;
	logic [SIZE_BITS-1:0] cfg_height = hpe_pkg::FRAME_HEIGHT_RESET;
	logic [THR_BITS-1:0]  cfg_thr    = hpe_pkg::THRESHOLD_RESET;

	pixel_t    pixels_pending [$];
	peak_rec_t peaks_due [$];
	pixel_t    next_pix;
	peak_rec_t peak_head;

	bit pix_xfer = 1'b0;
	bit cfg_xfer = 1'b0;
	bit calm = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int pix_pushed = 0;
	int pix_accepted = 0;
	int peaks_checked = 0;
	int cfg_writes = 0;
	int phases = 0;
	int err_cnt = 0;
	int cycle_cnt = 0;

	function automatic int unsigned frame_dim(logic [SIZE_BITS-1:0] v, int unsigned hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic int pick_gap();
		int x;
		if (calm)
			return 0;
		x = $urandom_range(0, 99);
		if (x < 60)
			return 0;
		if (x < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [SCORE_BITS-1:0] rand_score(fill_t fill,
		logic [SCORE_BITS-1:0] flat);
		case (fill)
			FILL_FULL: return SCORE_BITS'($urandom);
			FILL_TIES: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return '1;
					2: return SCORE_BITS'(40000);
					default: return SCORE_BITS'(40001);
				endcase
			end
			FILL_SPIKY: begin
				if ($urandom_range(0, 7) == 0)
					return SCORE_BITS'($urandom);
				return SCORE_BITS'($urandom_range(0, 255));
			end
			default: return flat;
		endcase
	endfunction

	function automatic bit is_peak(int wr, int wc, int k, int unsigned r, int unsigned c);
		logic [SCORE_BITS-1:0] s;
		int rr, cc;
		s = win[wr][wc][k];
		for (rr = wr - 1; rr <= wr + 1; rr++) begin
			for (cc = wc - 1; cc <= wc + 1; cc++) begin
				if (rr < 0 || rr > 2 || cc < 0 || cc > 2)
					continue;
				// outside the frame counts as minus infinity
				if (r + rr < 2 || c + cc < 2)
					continue;
				if (win[rr][cc][k] > s)
					return 1'b0;
			end
		end
		return s > cfg_thr;
	endfunction

	function automatic int pixels_left_in_frame();
		int unsigned w, h, row_left;
		w = frame_dim(cfg_width, MAX_WIDTH);
		h = frame_dim(cfg_height, MAX_HEIGHT);
		row_left = (col_cnt >= w - 1) ? 1 : w - col_cnt;
		return row_left + ((row_cnt >= h - 1) ? 0 : (h - 1 - row_cnt) * w);
	endfunction

	task automatic predict_peaks(input logic [SCORE_BITS-1:0] veh,
		input logic [SCORE_BITS-1:0] per);
		int unsigned w, h, c, r;
		bit lastc, lastr, rsel, csel;
		logic [SCORE_BITS-1:0] cur [NUM_CLASSES];
		peak_rec_t found [$];
		peak_rec_t rec;
		int i, k;
		w = frame_dim(cfg_width, MAX_WIDTH);
		h = frame_dim(cfg_height, MAX_HEIGHT);
		c = (col_cnt >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_cnt;
		r = row_cnt;
		cur[0] = veh;
		cur[1] = per;
		for (i = 0; i < 3; i++) begin
			for (k = 0; k < NUM_CLASSES; k++) begin
				win[i][0][k] = win[i][1][k];
				win[i][1][k] = win[i][2][k];
			end
		end
		for (k = 0; k < NUM_CLASSES; k++) begin
			win[0][2][k] = line_old[c][k];
			win[1][2][k] = line_new[c][k];
			win[2][2][k] = cur[k];
			line_old[c][k] = line_new[c][k];
			line_new[c][k] = cur[k];
		end
		lastc = c >= w - 1;
		lastr = r >= h - 1;
		// centers in raster order: (r-1,c-1), (r-1,c), (r,c-1), (r,c)
		for (i = 0; i < 4; i++) begin
			rsel = (i / 2) != 0;
			csel = (i % 2) != 0;
			if (!((rsel ? lastr : r >= 1) && (csel ? lastc : c >= 1)))
				continue;
			for (k = 0; k < NUM_CLASSES; k++) begin
				if (is_peak(1 + rsel, 1 + csel, k, r, c)) begin
					rec.col   = POS_BITS'(c - 1 + csel);
					rec.row   = POS_BITS'(r - 1 + rsel);
					rec.cls   = k[0];
					rec.score = win[1 + rsel][1 + csel][k];
					rec.last  = 1'b0;
					found.push_back(rec);
				end
			end
		end
		for (i = 0; i < found.size(); i++) begin
			rec = found[i];
			rec.last = (i == found.size() - 1);
			peaks_due.push_back(rec);
		end
		if (lastc) begin
			col_cnt = 0;
			row_cnt = lastr ? 0 : r + 1;
		end else begin
			col_cnt = c + 1;
		end
	endtask

	task automatic report_field(input string name, input longint unsigned want,
		input longint unsigned got);
		err_cnt++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
	endtask

	// transfer monitor and checker
	always @(posedge clk) begin
		pix_xfer <= pix.valid && pix.ready;
		cfg_xfer <= cfg.valid && cfg.ready;
		if (cfg.valid && cfg.ready) begin
			case (hpe_pkg::reg_index_t'(cfg.index))
				hpe_pkg::REG_FRAME_WIDTH: cfg_width = cfg.data[SIZE_BITS-1:0];
				hpe_pkg::REG_FRAME_HEIGHT: cfg_height = cfg.data[SIZE_BITS-1:0];
				hpe_pkg::REG_SCORE_THRESHOLD: cfg_thr = cfg.data[THR_BITS-1:0];
				default: ;
			endcase
		end
		if (pix.valid && pix.ready) begin
			predict_peaks(pix.score_vehicle, pix.score_person);
			pix_accepted++;
		end
		if (peak.valid && peak.ready) begin
			if (peaks_due.size() == 0) begin
				err_cnt++;
				$display({"%0t: unexpected peak, expected none, ",
					"actual col %0d row %0d class %0d score %0d"},
					$time, peak.peak_col, peak.peak_row, peak.peak_class, peak.peak_score);
			end else begin
				peak_head = peaks_due.pop_front();
				peaks_checked++;
				if (peak.peak_col !== peak_head.col)
					report_field("peak_col", peak_head.col, peak.peak_col);
				if (peak.peak_row !== peak_head.row)
					report_field("peak_row", peak_head.row, peak.peak_row);
				if (peak.peak_class !== peak_head.cls)
					report_field("peak_class", peak_head.cls, peak.peak_class);
				if (peak.peak_score !== peak_head.score)
					report_field("peak_score", peak_head.score, peak.peak_score);
				if (peak.last_of_item !== peak_head.last)
					report_field("last_of_item", peak_head.last, peak.last_of_item);
			end
		end
	end

	// pixel driver
	always @(negedge clk) begin
		if (!pix.valid || pix_xfer) begin
			if (send_gap > 0) begin
				pix.valid <= 1'b0;
				send_gap--;
			end else if (pixels_pending.size() != 0) begin
				next_pix = pixels_pending.pop_front();
				pix.valid <= 1'b1;
				pix.score_vehicle <= next_pix.veh;
				pix.score_person <= next_pix.per;
				send_gap = pick_gap();
			end else begin
				pix.valid <= 1'b0;
			end
		end
	end

	// peak backpressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			peak.ready <= 1'b0;
			stall_left--;
		end else begin
			peak.ready <= 1'b1;
			if ($urandom_range(0, 2) == 0)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d peaks still expected", $time, cycle_cnt,
				peaks_due.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic push_pixel(input logic [SCORE_BITS-1:0] veh,
		input logic [SCORE_BITS-1:0] per);
		pixel_t p;
		p.veh = veh;
		p.per = per;
		pixels_pending.push_back(p);
		pix_pushed++;
	endtask

	task automatic push_random(input int count);
		repeat (count)
			push_pixel(SCORE_BITS'($urandom), SCORE_BITS'($urandom));
	endtask

	task automatic wait_sent();
		while (pix_accepted != pix_pushed)
			@(negedge clk);
	endtask

	task automatic wait_idle();
		wait_sent();
		while (peaks_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input hpe_pkg::reg_index_t idx,
		input logic [CFG_DATA_BITS-1:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do
			@(negedge clk);
		while (!cfg_xfer);
		cfg.valid <= 1'b0;
		cfg_writes++;
	endtask

	task automatic set_frame(input logic [CFG_DATA_BITS-1:0] w, input logic [CFG_DATA_BITS-1:0] h,
		input logic [CFG_DATA_BITS-1:0] thr);
		write_reg(hpe_pkg::REG_FRAME_WIDTH, w);
		write_reg(hpe_pkg::REG_FRAME_HEIGHT, h);
		write_reg(hpe_pkg::REG_SCORE_THRESHOLD, thr);
		phases++;
	endtask

	task automatic feed_to_frame_end(input fill_t fill, output int n);
		logic [SCORE_BITS-1:0] flat;
		wait_sent();
		n = pixels_left_in_frame();
		flat = SCORE_BITS'($urandom);
		repeat (n)
			push_pixel(rand_score(fill, flat), rand_score(fill, flat));
	endtask

	initial begin
		int r, c, n, part, random_sent, guard;
		int unsigned w, h;
		logic [CFG_DATA_BITS-1:0] w_data, h_data, thr;
		fill_t fill;

		arst_n = 1'b0;
		pix.valid = 1'b0;
		pix.score_vehicle = '0;
		pix.score_person = '0;
		cfg.valid = 1'b0;
		cfg.index = hpe_pkg::REG_FRAME_WIDTH;
		cfg.data = '0;
		peak.ready = 1'b1;
		for (c = 0; c < MAX_WIDTH; c++) begin
			line_old[c] = '{default: '0};
			line_new[c] = '{default: '0};
		end
		win = '{default: '{default: '{default: '0}}};
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// reset width and threshold on a single row, then the row cut short
		calm = 1'b1;
		write_reg(hpe_pkg::REG_FRAME_HEIGHT, 1);
		phases++;
		push_random(20);
		wait_idle();
		write_reg(hpe_pkg::REG_FRAME_WIDTH, 21);
		feed_to_frame_end(FILL_FULL, n);
		calm = 1'b0;
		wait_idle();

		// flat 2x2 frame: every pixel ties, eight peaks from the last pixel
		set_frame(2, 2, 0);
		repeat (4) push_pixel('1, '1);
		wait_idle();

		// single pixel frames, full scale and zero at zero threshold
		set_frame(1, 1, 16'hFFFE);
		push_pixel('1, '1);
		wait_idle();
		write_reg(hpe_pkg::REG_SCORE_THRESHOLD, 0);
		push_pixel('0, 1);
		wait_idle();

		// score equal to the threshold is not a peak
		set_frame(3, 3, 100);
		for (r = 0; r < 3; r++)
			for (c = 0; c < 3; c++)
				if (r == 1 && c == 1)
					push_pixel(101, 100);
				else
					push_pixel(50, 50);
		wait_idle();

		// size shrink while inside a frame
		set_frame(4, 4, 0);
		push_random(6);
		wait_idle();
		write_reg(hpe_pkg::REG_FRAME_WIDTH, 2);
		write_reg(hpe_pkg::REG_FRAME_HEIGHT, 2);
		write_reg(hpe_pkg::REG_SCORE_THRESHOLD, 16'h8000);
		feed_to_frame_end(FILL_FULL, n);
		wait_idle();

		// clamped sizes and masked upper data bits, frames closed by a shrink
		calm = 1'b1;
		set_frame(11'h7FF, 1, 16'h8000);
		push_random(24);
		wait_idle();
		write_reg(hpe_pkg::REG_FRAME_WIDTH, 25);
		feed_to_frame_end(FILL_FULL, n);
		wait_idle();
		set_frame(16'hF801, 11'h7FF, 16'h4000);
		push_random(24);
		wait_idle();
		write_reg(hpe_pkg::REG_FRAME_HEIGHT, 25);
		feed_to_frame_end(FILL_FULL, n);
		wait_idle();
		calm = 1'b0;
		set_frame(0, 3, 0);
		feed_to_frame_end(FILL_SPIKY, n);
		wait_idle();
		set_frame(5, 0, 1000);
		feed_to_frame_end(FILL_TIES, n);
		wait_idle();

		random_sent = 0;
		while (random_sent < RANDOM_PIXELS) begin
			calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) == 0) begin
				w = $urandom_range(13, 40);
				h = $urandom_range(1, 3);
			end else begin
				w = $urandom_range(1, 12);
				h = $urandom_range(1, 8);
			end
			w_data = CFG_DATA_BITS'(w);
			if ($urandom_range(0, 3) == 0)
				w_data[CFG_DATA_BITS-1:SIZE_BITS] = (CFG_DATA_BITS - SIZE_BITS)'($urandom);
			h_data = CFG_DATA_BITS'(h);
			case ($urandom_range(0, 5))
				0: thr = 0;
				1: thr = 16'hFFFF;
				2: thr = 16'h8000;
				3: thr = CFG_DATA_BITS'($urandom);
				default: thr = CFG_DATA_BITS'($urandom_range(0, 2000));
			endcase
			fill = fill_t'($urandom_range(0, 3));
			set_frame(w_data, h_data, thr);
			if ($urandom_range(0, 3) == 0) begin
				wait_sent();
				part = $urandom_range(1, pixels_left_in_frame());
				repeat (part)
					push_pixel(rand_score(fill, 16'h9000), rand_score(fill, 16'h9000));
				random_sent += part;
				wait_idle();
				write_reg(hpe_pkg::REG_FRAME_WIDTH,
					CFG_DATA_BITS'($urandom_range(1, frame_dim(cfg_width, MAX_WIDTH))));
				write_reg(hpe_pkg::REG_FRAME_HEIGHT, CFG_DATA_BITS'($urandom_range(1, 8)));
				write_reg(hpe_pkg::REG_SCORE_THRESHOLD, CFG_DATA_BITS'($urandom_range(0, 3000)));
			end
			repeat ($urandom_range(1, 2)) begin
				feed_to_frame_end(fill, n);
				random_sent += n;
			end
			wait_idle();
		end

		wait_sent();
		guard = 0;
		while (peaks_due.size() != 0 && guard < 50000) begin
			@(negedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (peaks_due.size() != 0) begin
			err_cnt++;
			$display("%0t: %0d expected peaks never arrived", $time, peaks_due.size());
		end

		$display("run covered %0d pixels in %0d frame settings with %0d register writes",
			pix_accepted, phases, cfg_writes);
		$display("%0d peak transfers checked, %0d mismatches", peaks_checked, err_cnt);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/hpe_pkg.sv
rtl/hpe_if.sv
rtl/hpe_line_mem.sv
rtl/hpe_peak_emit.sv
rtl/heatmap_peak_extract_3x3.sv
test/tb_heatmap_peak_extract_3x3.sv
